@@ src/xbmq_pkg.sv @@
// shared types, constants and word helpers for the xor basis max query block
package xbmq_pkg;

    localparam int WORD_BITS = 32;
    localparam int IO_BITS   = 32;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IO_BITS-1:0]   io_word_t;

    // word moving down the cell chain
    typedef struct packed {
        logic  valid;
        logic  last;
        word_t word;
        word_t acc;
    } token_t;

    // per-cell control from the top level
    typedef struct packed {
        logic  advance;
        word_t bit_mask;
    } cell_ctrl_t;

    // cut or zero-extend an io word to the basis width
    function automatic word_t fit_word(input io_word_t v);
        word_t r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (i < IO_BITS)
                r[i] = v[i];
        end
        return r;
    endfunction

    // low io bits of a basis word
    function automatic io_word_t to_io(input word_t w);
        io_word_t r;
        r = '0;
        for (int i = 0; i < IO_BITS; i++)
        begin
            if (i < WORD_BITS)
                r[i] = w[i];
        end
        return r;
    endfunction

endpackage

@@ src/xor_basis_max_query_core.sv @@
// top level: chain of basis cells, one per bit from msb down, and the result register
// a result enters the result register once its last word has passed every cell of the chain
// throughput: one word per cycle, set by the single-step cell chain; the whole chain
//   holds while a finished result waits and out_ready is low
// reset: all rows invalid (empty basis), chain and result register empty
// the basis empties itself as each last word passes, so sets may follow back to back
module xor_basis_max_query_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               value,
    input  logic [31:0]               query_key,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               max_value
);
    import xbmq_pkg::*;

    token_t   chain [0:WORD_BITS];
    logic     advance;
    logic     out_valid_reg;
    logic     out_valid_next;
    io_word_t max_value_reg;
    io_word_t max_value_next;
    token_t   tail;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        chain[0].valid = in_valid;
        chain[0].last  = last;
        chain[0].word  = fit_word(value);
        chain[0].acc   = fit_word(query_key);
    end

    genvar gi;
    generate
        for (gi = 0; gi < WORD_BITS; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            always_comb
            begin
                ctrl.advance  = advance;
                ctrl.bit_mask = word_t'(1) << (WORD_BITS - 1 - gi);
            end
            xbmq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[WORD_BITS];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        max_value_next = max_value_reg;
        if (advance)
        begin
            out_valid_next = tail.valid && tail.last;
            if (tail.valid && tail.last)
                max_value_next = to_io(tail.acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        max_value_reg <= max_value_next;
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;

    // a waiting result freezes the chain
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // a new result only comes from a last word at the chain tail
    a_result_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(tail.valid && tail.last))
        else $error("result without last word at tail");

    // an accepted word lands in the first cell
    a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> chain[1].valid)
        else $error("accepted word lost at chain head");

endmodule

@@ src/xbmq_cell.sv @@
// one basis cell: holds the row for a single leading bit and reduces passing words
module xbmq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  xbmq_pkg::cell_ctrl_t ctrl,
    input  xbmq_pkg::token_t   tok_in,
    output xbmq_pkg::token_t   tok_out
);
    import xbmq_pkg::*;

    word_t  row_reg;
    word_t  row_next;
    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;

    logic   hit;
    logic   store;
    logic   valid_eff;
    word_t  row_eff;

    always_comb
    begin
        hit       = |(tok_in.word & ctrl.bit_mask);
        store     = tok_in.valid && hit && !valid_reg;
        valid_eff = valid_reg || store;
        row_eff   = store ? tok_in.word : row_reg;

        tok_next       = tok_in;
        tok_next.valid = tok_in.valid;
        if (hit && valid_reg)
            tok_next.word = tok_in.word ^ row_reg;
        else if (store)
            tok_next.word = '0;
        // greedy query step uses the row as updated by this same word
        if (valid_eff && !(|(tok_in.acc & ctrl.bit_mask)))
            tok_next.acc = tok_in.acc ^ row_eff;

        row_next   = row_eff;
        valid_next = valid_reg;
        if (tok_in.valid)
        begin
            if (tok_in.last)
                valid_next = 1'b0;
            else if (store)
                valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
            row_reg <= row_next;
    end

    assign tok_out = tok_reg;

endmodule
